// ----- design/srlb_pkg.sv -----
`timescale 1ns / 1ps

package srlb_pkg;

	// Echo ticks that make up one centimetre of range.
	localparam int unsigned TICKS_PER_CM = 58;

	// Sub-centimetre tick counter holds values below TICKS_PER_CM.
	localparam int unsigned SUB_W = (TICKS_PER_CM > 1) ? $clog2(TICKS_PER_CM) : 1;

	// Field and register widths.
	localparam int unsigned TRIG_W   = 10;
	localparam int unsigned HALF_W   = 24;
	localparam int unsigned DIST_W   = 12;
	localparam int unsigned SETTLE_W = 20;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned DATA_W   = 24;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Ranging phases.
	localparam logic [1:0] PH_TRIGGER = 2'd0;
	localparam logic [1:0] PH_WAIT    = 2'd1;
	localparam logic [1:0] PH_ECHO    = 2'd2;
	localparam logic [1:0] PH_SETTLE  = 2'd3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_TRIGGER_TICKS    = 3'd0;
	localparam logic [IDX_W-1:0] REG_BLINK_HALF_TICKS = 3'd1;
	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT_CM    = 3'd2;
	localparam logic [IDX_W-1:0] REG_VALID_LIMIT_CM   = 3'd3;
	localparam logic [IDX_W-1:0] REG_SETTLE_TICKS     = 3'd4;

	// Configuration reset values.
	localparam logic [TRIG_W-1:0]   RST_TRIGGER_TICKS    = 10'd20;
	localparam logic [HALF_W-1:0]   RST_BLINK_HALF_TICKS = 24'd250000;
	localparam logic [DIST_W-1:0]   RST_NEAR_LIMIT_CM    = 12'd12;
	localparam logic [DIST_W-1:0]   RST_VALID_LIMIT_CM   = 12'd100;
	localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS     = 20'd30000;

	typedef struct packed {
		logic [TRIG_W-1:0]   trigger_ticks;
		logic [HALF_W-1:0]   blink_half_ticks;
		logic [DIST_W-1:0]   near_limit_cm;
		logic [DIST_W-1:0]   valid_limit_cm;
		logic [SETTLE_W-1:0] settle_ticks;
	} cfg_t;

	// Reading published by the ranger and whether it is in the near band.
	typedef struct packed {
		logic publish;
		logic near;
	} rng_evt_t;

endpackage

// ----- design/srlb_ranger.sv -----
`timescale 1ns / 1ps

module srlb_ranger (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             echo_level,
	input  srlb_pkg::cfg_t                   cfg,
	output logic                             trig,
	output logic [srlb_pkg::DIST_W-1:0]      last_cm,
	output srlb_pkg::rng_evt_t               evt
);

	logic [1:0]                          phase_q, phase_d;
	logic [srlb_pkg::SETTLE_W-1:0]       ph_ticks_q, ph_ticks_d, ph_ticks_inc;
	logic [srlb_pkg::SUB_W-1:0]          sub_q, sub_d, cnt_sub;
	logic [srlb_pkg::SUB_W:0]            sub_sum;
	logic [srlb_pkg::DIST_W-1:0]         cm_q, cm_d, cnt_cm, cm_inc;
	logic [srlb_pkg::DIST_W-1:0]         latest_q, latest_d;
	logic                                start, wrap;
	logic [srlb_pkg::SUB_W-1:0]          sub_next;
	logic [srlb_pkg::DIST_W-1:0]         cm_next;

	// Echo tick counting: a rising echo starts from zero, otherwise continue.
	assign start    = (phase_q == srlb_pkg::PH_WAIT);
	assign cnt_sub  = start ? '0 : sub_q;
	assign cnt_cm   = start ? '0 : cm_q;
	assign sub_sum  = {1'b0, cnt_sub} + 1'b1;
	assign wrap     = (sub_sum >= (srlb_pkg::SUB_W+1)'(srlb_pkg::TICKS_PER_CM));
	assign cm_inc   = (cnt_cm == srlb_pkg::DIST_MAX) ? cnt_cm : cnt_cm + 1'b1;
	assign sub_next = wrap ? '0 : sub_sum[srlb_pkg::SUB_W-1:0];
	assign cm_next  = wrap ? cm_inc : cnt_cm;

	assign ph_ticks_inc = ph_ticks_q + 1'b1;

	// Phase sequencing for one tick.
	always_comb begin
		phase_d     = phase_q;
		ph_ticks_d  = ph_ticks_q;
		sub_d       = sub_q;
		cm_d        = cm_q;
		latest_d    = latest_q;
		trig        = 1'b0;
		evt         = '0;
		case (phase_q)
			srlb_pkg::PH_WAIT: begin
				if (echo_level) begin
					phase_d = srlb_pkg::PH_ECHO;
					sub_d   = sub_next;
					cm_d    = cm_next;
				end
			end
			srlb_pkg::PH_ECHO: begin
				if (echo_level) begin
					sub_d = sub_next;
					cm_d  = cm_next;
				end else begin
					ph_ticks_d = '0;
					if (cm_q < cfg.valid_limit_cm) begin
						latest_d    = cm_q;
						evt.publish = 1'b1;
						evt.near    = (cm_q <= cfg.near_limit_cm);
						phase_d     = (cfg.settle_ticks == '0) ? srlb_pkg::PH_TRIGGER
							: srlb_pkg::PH_SETTLE;
					end else begin
						phase_d = srlb_pkg::PH_TRIGGER;
					end
				end
			end
			srlb_pkg::PH_SETTLE: begin
				ph_ticks_d = ph_ticks_inc;
				if (ph_ticks_inc >= cfg.settle_ticks) begin
					phase_d    = srlb_pkg::PH_TRIGGER;
					ph_ticks_d = '0;
				end
			end
			default: begin
				trig       = 1'b1;
				ph_ticks_d = ph_ticks_inc;
				if (ph_ticks_inc >= srlb_pkg::SETTLE_W'(cfg.trigger_ticks)) begin
					phase_d    = srlb_pkg::PH_WAIT;
					ph_ticks_d = '0;
				end
			end
		endcase
	end

	assign last_cm = latest_d;

	// State registers advance once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= srlb_pkg::PH_TRIGGER;
			ph_ticks_q <= '0;
			sub_q      <= '0;
			cm_q       <= '0;
			latest_q   <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			ph_ticks_q <= ph_ticks_d;
			sub_q      <= sub_d;
			cm_q       <= cm_d;
			latest_q   <= latest_d;
		end
	end

endmodule

// ----- design/srlb_blinker.sv -----
`timescale 1ns / 1ps

module srlb_blinker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  srlb_pkg::rng_evt_t   evt,
	input  srlb_pkg::cfg_t       cfg,
	output logic                 led
);

	logic                          blinking_q, blinking_d, blink_m;
	logic                          led_q, led_d, led_m;
	logic [srlb_pkg::HALF_W-1:0]   bt_q, bt_d, bt_m, bt_inc;

	// Mode change from a published reading, seen on the LED this tick.
	always_comb begin
		blink_m = blinking_q;
		led_m   = led_q;
		bt_m    = bt_q;
		if (evt.publish) begin
			if (evt.near) begin
				if (!blinking_q) begin
					blink_m = 1'b1;
					led_m   = 1'b1;
					bt_m    = '0;
				end
			end else begin
				blink_m = 1'b0;
				led_m   = 1'b0;
				bt_m    = '0;
			end
		end
	end

	assign led    = led_m;
	assign bt_inc = bt_m + 1'b1;

	// Half-period counter advances after the LED level is taken.
	always_comb begin
		blinking_d = blink_m;
		led_d      = led_m;
		bt_d       = bt_m;
		if (blink_m) begin
			if (bt_inc >= cfg.blink_half_ticks) begin
				bt_d  = '0;
				led_d = !led_m;
			end else begin
				bt_d = bt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blinking_q <= 1'b0;
			led_q      <= 1'b0;
			bt_q       <= '0;
		end else if (en) begin
			blinking_q <= blinking_d;
			led_q      <= led_d;
			bt_q       <= bt_d;
		end
	end

endmodule

// ----- design/sonar_range_led_blinker.sv -----
`timescale 1ns / 1ps

// Ultrasonic ranging controller with a proximity LED blinker. Each input word is
// one microsecond tick carrying the sampled echo pin level; each accepted word
// yields exactly one output word (trigger pin level, LED level, latest published
// distance in centimetres and a flag on the tick a reading is published). The
// block takes one word per clock cycle; the result is loaded into the output
// register at the edge that accepts the word and can be taken at the next edge.
// That single output register, released by out_ready, is the only stage, so
// input is stalled only while it holds a word that is not taken in the same
// cycle. Configuration writes are accepted in any cycle and should be made only
// while no words are in flight.
module sonar_range_led_blinker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              echo_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              trigger_level,
	output logic                              led_level,
	output logic [srlb_pkg::DIST_W-1:0]       distance_cm,
	output logic                              distance_new,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srlb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [srlb_pkg::DATA_W-1:0]       cfg_data
);

	srlb_pkg::cfg_t                  cfg_q;
	srlb_pkg::rng_evt_t              evt;
	logic                            accept;
	logic                            trig;
	logic                            led;
	logic [srlb_pkg::DIST_W-1:0]     last_cm;
	logic                            out_valid_q;
	logic                            trigger_level_q, led_level_q, distance_new_q;
	logic [srlb_pkg::DIST_W-1:0]     distance_cm_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks    <= srlb_pkg::RST_TRIGGER_TICKS;
			cfg_q.blink_half_ticks <= srlb_pkg::RST_BLINK_HALF_TICKS;
			cfg_q.near_limit_cm    <= srlb_pkg::RST_NEAR_LIMIT_CM;
			cfg_q.valid_limit_cm   <= srlb_pkg::RST_VALID_LIMIT_CM;
			cfg_q.settle_ticks     <= srlb_pkg::RST_SETTLE_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srlb_pkg::REG_TRIGGER_TICKS:
					cfg_q.trigger_ticks <= cfg_data[srlb_pkg::TRIG_W-1:0];
				srlb_pkg::REG_BLINK_HALF_TICKS:
					cfg_q.blink_half_ticks <= cfg_data[srlb_pkg::HALF_W-1:0];
				srlb_pkg::REG_NEAR_LIMIT_CM:
					cfg_q.near_limit_cm <= cfg_data[srlb_pkg::DIST_W-1:0];
				srlb_pkg::REG_VALID_LIMIT_CM:
					cfg_q.valid_limit_cm <= cfg_data[srlb_pkg::DIST_W-1:0];
				srlb_pkg::REG_SETTLE_TICKS:
					cfg_q.settle_ticks <= cfg_data[srlb_pkg::SETTLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input is taken whenever the output register is free or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	srlb_ranger u_ranger (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.echo_level (echo_level),
		.cfg        (cfg_q),
		.trig       (trig),
		.last_cm    (last_cm),
		.evt        (evt)
	);

	srlb_blinker u_blinker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.evt    (evt),
		.cfg    (cfg_q),
		.led    (led)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trigger_level_q <= trig;
			led_level_q     <= led;
			distance_cm_q   <= last_cm;
			distance_new_q  <= evt.publish;
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_level = trigger_level_q;
	assign led_level     = led_level_q;
	assign distance_cm   = distance_cm_q;
	assign distance_new  = distance_new_q;

	// A trigger tick never publishes a reading.
	a_trig_no_publish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_level |-> !distance_new)
		else $error("publish flagged on a trigger tick");

	// An accepted word always lands in the output register.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word did not reach the output register");

	// An empty output register never stalls the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import srlb_pkg::*;

	// One expected output word per accepted echo tick.
	typedef struct packed {
		logic              trigger_level;
		logic              led_level;
		logic [DIST_W-1:0] distance_cm;
		logic              distance_new;
	} tick_word_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              echo_level = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              trigger_level;
	logic              led_level;
	logic [DIST_W-1:0] distance_cm;
	logic              distance_new;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	sonar_range_led_blinker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.echo_level    (echo_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger_level (trigger_level),
		.led_level     (led_level),
		.distance_cm   (distance_cm),
		.distance_new  (distance_new),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Ranger image kept by the testbench, starting from the reset state.
	cfg_t              ranger_cfg = '{RST_TRIGGER_TICKS, RST_BLINK_HALF_TICKS,
		RST_NEAR_LIMIT_CM, RST_VALID_LIMIT_CM, RST_SETTLE_TICKS};
	logic [1:0]        ph_q = PH_TRIGGER;
	logic [SETTLE_W-1:0] ph_ticks_q = '0;
	logic [9:0]        sub_ticks_q = '0;
	logic [DIST_W-1:0] cm_count_q = '0;
	logic [DIST_W-1:0] last_dist_q = '0;
	logic              blinking_q = 1'b0;
	logic              led_q = 1'b0;
	logic [HALF_W-1:0] blink_cnt_q = '0;

	tick_word_t  expected_ticks[$];
	tick_word_t  seen_word;
	tick_word_t  want_word;
	int unsigned mismatches = 0;
	int unsigned ticks_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit far above the slowest legal run.
	initial begin
		#5000000;
		$display("tb_top: errors");
		$finish;
	end

	// One echo tick of high time; every 58 of them make a centimetre.
	function automatic void add_echo_tick();
		sub_ticks_q = sub_ticks_q + 10'd1;
		if (sub_ticks_q >= TICKS_PER_CM) begin
			sub_ticks_q = '0;
			if (cm_count_q != DIST_MAX)
				cm_count_q = cm_count_q + 1'b1;
		end
	endfunction

	// Advance the ranger image by one tick and return the word it should emit.
	function automatic tick_word_t step_ranger(input logic echo);
		tick_word_t w;
		w = '0;
		case (ph_q)
			PH_WAIT: begin
				if (echo) begin
					ph_q = PH_ECHO;
					sub_ticks_q = '0;
					cm_count_q = '0;
					add_echo_tick();
				end
			end
			PH_ECHO: begin
				if (echo) begin
					add_echo_tick();
				end else begin
					ph_ticks_q = '0;
					if (cm_count_q < ranger_cfg.valid_limit_cm) begin
						last_dist_q = cm_count_q;
						w.distance_new = 1'b1;
						if (cm_count_q <= ranger_cfg.near_limit_cm) begin
							// A blink already running is left alone.
							if (!blinking_q) begin
								blinking_q = 1'b1;
								led_q = 1'b1;
								blink_cnt_q = '0;
							end
						end else begin
							blinking_q = 1'b0;
							led_q = 1'b0;
							blink_cnt_q = '0;
						end
						ph_q = (ranger_cfg.settle_ticks == '0) ? PH_TRIGGER : PH_SETTLE;
					end else begin
						ph_q = PH_TRIGGER;
					end
				end
			end
			PH_SETTLE: begin
				ph_ticks_q = ph_ticks_q + 1'b1;
				if (ph_ticks_q >= ranger_cfg.settle_ticks) begin
					ph_q = PH_TRIGGER;
					ph_ticks_q = '0;
				end
			end
			default: begin
				w.trigger_level = 1'b1;
				ph_ticks_q = ph_ticks_q + 1'b1;
				if (ph_ticks_q >= ranger_cfg.trigger_ticks) begin
					ph_q = PH_WAIT;
					ph_ticks_q = '0;
				end
			end
		endcase
		w.led_level = led_q;
		w.distance_cm = last_dist_q;
		// The blink counter moves after the LED level is taken.
		if (blinking_q) begin
			blink_cnt_q = blink_cnt_q + 1'b1;
			if (blink_cnt_q >= ranger_cfg.blink_half_ticks) begin
				blink_cnt_q = '0;
				led_q = ~led_q;
			end
		end
		return w;
	endfunction

	// Receiver stalls at random, decided at each falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Each output word taken is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word = '{trigger_level, led_level, distance_cm, distance_new};
			if (expected_ticks.size() == 0) begin
				$error("output word with no expectation pending");
				mismatches++;
			end else begin
				want_word = expected_ticks.pop_front();
				if (seen_word.trigger_level !== want_word.trigger_level) begin
					$error("trigger_level expected %0d actual %0d",
						want_word.trigger_level, seen_word.trigger_level);
					mismatches++;
				end
				if (seen_word.led_level !== want_word.led_level) begin
					$error("led_level expected %0d actual %0d",
						want_word.led_level, seen_word.led_level);
					mismatches++;
				end
				if (seen_word.distance_cm !== want_word.distance_cm) begin
					$error("distance_cm expected %0d actual %0d",
						want_word.distance_cm, seen_word.distance_cm);
					mismatches++;
				end
				if (seen_word.distance_new !== want_word.distance_new) begin
					$error("distance_new expected %0d actual %0d",
						want_word.distance_new, seen_word.distance_new);
					mismatches++;
				end
			end
		end
	end

	// Send one echo tick word; entered and left at a falling edge.
	task automatic send_tick(input logic echo);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		echo_level <= echo;
		do @(posedge clk); while (!in_ready);
		expected_ticks.push_back(step_ranger(echo));
		ticks_sent++;
		@(negedge clk);
	endtask

	// Hold the sender off until every pending word has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
	endtask

	// Register write, made only with nothing in flight.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		drain_results();
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TRIGGER_TICKS:    ranger_cfg.trigger_ticks = data[TRIG_W-1:0];
			REG_BLINK_HALF_TICKS: ranger_cfg.blink_half_ticks = data[HALF_W-1:0];
			REG_NEAR_LIMIT_CM:    ranger_cfg.near_limit_cm = data[DIST_W-1:0];
			REG_VALID_LIMIT_CM:   ranger_cfg.valid_limit_cm = data[DIST_W-1:0];
			REG_SETTLE_TICKS:     ranger_cfg.settle_ticks = data[SETTLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_lows(input int unsigned n);
		repeat (n) send_tick(1'b0);
	endtask

	// One measurement: ride out trigger and settle, then an echo pulse of the
	// given length. A noisy lead puts random echo levels where they are ignored.
	task automatic range_once(input int unsigned echo_ticks, input bit noisy_lead);
		int unsigned lead;
		lead = $urandom_range(0, 3);
		while (ph_q != PH_WAIT)
			send_tick(noisy_lead ? ($urandom_range(1) != 0) : 1'b0);
		send_lows(lead);
		repeat (echo_ticks) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// Reset register values: one near reading starts the blink.
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		range_once(5 * TICKS_PER_CM + 3, 1'b0);
		send_lows(10);
	endtask

	// Zero trigger, zero settle and zero half period, near and far readings.
	task automatic test_zero_settings();
		write_reg(REG_TRIGGER_TICKS, '0);
		write_reg(REG_SETTLE_TICKS, '0);
		write_reg(REG_BLINK_HALF_TICKS, '0);
		write_reg(REG_NEAR_LIMIT_CM, DATA_W'(4095));
		write_reg(REG_VALID_LIMIT_CM, DATA_W'(4095));
		// Near reading while already blinking.
		range_once(1, 1'b0);
		write_reg(REG_NEAR_LIMIT_CM, '0);
		// A far reading stops the blink.
		range_once(TICKS_PER_CM, 1'b0);
		write_reg(REG_NEAR_LIMIT_CM, DATA_W'(4095));
		// A fresh blink toggling every tick.
		range_once(1, 1'b0);
		send_lows(6);
		write_reg(REG_VALID_LIMIT_CM, '0);
		// Every reading dropped, then a long wait with no echo.
		range_once(10, 1'b0);
		range_once(0, 1'b0);
		send_lows(40);
	endtask

	// Largest register values, each cut short while it is running.
	task automatic test_register_maxima();
		write_reg(REG_TRIGGER_TICKS, DATA_W'(1023));
		write_reg(REG_BLINK_HALF_TICKS, DATA_W'(24'hFFFFFF));
		write_reg(REG_SETTLE_TICKS, DATA_W'(20'hFFFFF));
		write_reg(REG_VALID_LIMIT_CM, DATA_W'(4095));
		write_reg(REG_NEAR_LIMIT_CM, DATA_W'(1));
		// A far reading enters the longest settle pause.
		range_once(2 * TICKS_PER_CM + 1, 1'b0);
		send_lows(20);
		// Shrinking the settle mid-pause ends it on the next tick.
		write_reg(REG_SETTLE_TICKS, DATA_W'(3));
		send_lows(30);
		// Shrinking the trigger mid-pulse ends it on the next tick.
		write_reg(REG_TRIGGER_TICKS, DATA_W'(2));
		write_reg(REG_NEAR_LIMIT_CM, DATA_W'(4095));
		range_once(TICKS_PER_CM - 1, 1'b0);
		send_lows(20);
		range_once(TICKS_PER_CM + 2, 1'b0);
		send_lows(8);
	endtask

	// Readings on either side of the valid limit, one right at the near limit.
	task automatic test_limit_edges();
		write_reg(REG_TRIGGER_TICKS, DATA_W'(1));
		write_reg(REG_SETTLE_TICKS, DATA_W'(1));
		write_reg(REG_BLINK_HALF_TICKS, DATA_W'(5));
		write_reg(REG_NEAR_LIMIT_CM, DATA_W'(1));
		write_reg(REG_VALID_LIMIT_CM, DATA_W'(2));
		range_once(2 * TICKS_PER_CM - 1, 1'b0);
		range_once(2 * TICKS_PER_CM, 1'b0);
		send_lows(5);
	endtask

	// Mostly well-formed measurements with random lengths under random registers.
	task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
		input int unsigned n_ticks);
		int unsigned start;
		int unsigned pick;
		bit          held;
		held = 1'b0;
		write_reg(REG_TRIGGER_TICKS, ($urandom_range(9) == 0) ?
			DATA_W'($urandom_range(7, 60)) : DATA_W'($urandom_range(0, 6)));
		write_reg(REG_BLINK_HALF_TICKS, ($urandom_range(7) == 0) ?
			DATA_W'($urandom_range(31, 24'hFFFFFF)) : DATA_W'($urandom_range(0, 30)));
		write_reg(REG_NEAR_LIMIT_CM, ($urandom_range(7) == 0) ?
			DATA_W'(4095) : DATA_W'($urandom_range(0, 5)));
		write_reg(REG_VALID_LIMIT_CM, ($urandom_range(7) == 0) ?
			DATA_W'(4095) : DATA_W'($urandom_range(0, 7)));
		write_reg(REG_SETTLE_TICKS, ($urandom_range(7) == 0) ?
			'0 : DATA_W'($urandom_range(0, 25)));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = ticks_sent;
		while (ticks_sent - start < n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 45)
				range_once($urandom_range(1, 70), 1'b0);
			else if (pick < 70)
				range_once($urandom_range(70, 350), 1'b0);
			else if (pick < 80)
				range_once($urandom_range(1, 200), 1'b1);
			else if (pick < 86)
				range_once(0, 1'b0);
			else
				repeat ($urandom_range(1, 40)) send_tick($urandom_range(1) != 0);
			// Once per phase the sender waits for the block to empty.
			if (!held) begin
				drain_results();
				held = 1'b1;
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_zero_settings();
		test_register_maxima();
		test_limit_edges();
		test_random(0, 0, 140);
		test_random(72, 0, 140);
		test_random(0, 72, 140);
		test_random(8, 8, 140);
		drain_results();
		repeat (5) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
